// File: sv/min_priority_queue_macros.svh
// Assertion macros for the min_priority_queue block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_priority_queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_priority_queue assertion failed");

`endif

// File: sv/mpq_pkg.sv
// Package for the min_priority_queue block: sizes, status and command codes,
// entry and channel struct types, and the entry ordering function.
`default_nettype none

package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 7;
  localparam int PRIO_W   = 16;
  localparam int PIDX_W   = 16;
  localparam int DATA_W   = 32;
  localparam int ARR_W    = 32;

  localparam logic       CMD_PUSH = 1'b0;
  localparam logic       CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PIDX_W-1:0] pidx;
    logic [DATA_W-1:0] payload;
    logic [ARR_W-1:0]  arrival;
  } entry_t;

  typedef struct packed {
    logic              command;
    logic [PRIO_W-1:0] priority_req;
    logic [PIDX_W-1:0] process_index;
    logic [DATA_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PRIO_W-1:0] out_priority;
    logic [PIDX_W-1:0] out_process_index;
    logic [DATA_W-1:0] out_payload;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   lt;
    entry_t entry;
  } cell_link_t;

  // True when entry a leaves before entry b.
  function automatic logic goes_first(entry_t a, entry_t b);
    if (a.prio != b.prio) begin
      return a.prio < b.prio;
    end
    return a.arrival < b.arrival;
  endfunction

endpackage

`default_nettype wire

// File: sv/mpq_cell.sv
// One cell of the sorted chain: holds one entry and its valid bit.
// Depends on mpq_pkg for the entry, control and link types.
`default_nettype none

module mpq_cell
  import mpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire cell_link_t left,
  input  wire cell_link_t right,
  output cell_link_t      link
);

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  logic   lt;

  // This cell stays ahead of the incoming entry.
  assign lt = valid_r && goes_first(entry_r, ctrl.new_entry);

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (!lt) begin
        if (left.lt) begin
          valid_nxt = 1'b1;
          entry_nxt = ctrl.new_entry;
        end else begin
          // shift right: take the neighbor's entry
          valid_nxt = left.valid;
          entry_nxt = left.entry;
        end
      end
    end else if (ctrl.pop) begin
      // shift left toward the head
      valid_nxt = right.valid;
      entry_nxt = right.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign link.valid = valid_r;
  assign link.lt    = lt;
  assign link.entry = entry_r;

endmodule

`default_nettype wire

// File: sv/min_priority_queue.sv
// Minimum priority queue for a process scheduler: a chain of mpq_cell cells
// kept sorted by priority, then arrival order. Depends on mpq_pkg and the macros header.
//
// Usage:
//   in_*  : commands (push an entry or pop the minimum), valid/stall handshake.
//   out_* : one result per command: status, popped entry (zero unless a pop
//           succeeded) and occupancy after the command.
//   A command transfers when in_valid is high and in_stall is low. Its result
//   appears in the output register on the next cycle.
//   Throughput is one command per cycle while in_stall is low. Every cell
//   compares its entry with the incoming one and shifts by at most one place,
//   so a push or a pop completes in one step of the chain regardless of occupancy.
//   When the receiver stalls with a result waiting, in_stall rises and the
//   result is held until it transfers; a new command is taken in the same
//   cycle the waiting result leaves.
//   Reset (rst_n low, synchronous) empties the queue, clears the arrival
//   counter and drops any pending result. Storage needs no clearing pass.
//   Equal priorities leave in push order; a full queue refuses a push with
//   status 2, an empty queue answers a pop with status 1.
`default_nettype none
`include "min_priority_queue_macros.svh"

module min_priority_queue
  import mpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic             in_accept;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ARR_W-1:0] arrival_r, arrival_nxt;
  logic             is_full, is_empty;
  cell_ctrl_t       ctrl;
  cell_link_t       link [CAPACITY];
  cell_link_t       head_edge, tail_edge;
  logic [CAPACITY-1:0] valid_vec;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);

  assign ctrl.push              = in_accept && (in_item.command == CMD_PUSH) && !is_full;
  assign ctrl.pop               = in_accept && (in_item.command == CMD_POP) && !is_empty;
  assign ctrl.new_entry.prio    = in_item.priority_req;
  assign ctrl.new_entry.pidx    = in_item.process_index;
  assign ctrl.new_entry.payload = in_item.payload;
  assign ctrl.new_entry.arrival = arrival_r;

  // The head boundary always counts as ahead; the tail boundary is empty.
  assign head_edge.valid = 1'b1;
  assign head_edge.lt    = 1'b1;
  assign head_edge.entry = '0;
  assign tail_edge.valid = 1'b0;
  assign tail_edge.lt    = 1'b0;
  assign tail_edge.entry = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .left  ((i == 0) ? head_edge : link[(i == 0) ? 0 : i - 1]),
      .right ((i == CAPACITY - 1) ? tail_edge : link[(i == CAPACITY - 1) ? i : i + 1]),
      .link  (link[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  always_comb begin
    count_nxt   = count_r;
    arrival_nxt = arrival_r;
    if (ctrl.push) begin
      count_nxt   = count_r + CNT_W'(1);
      arrival_nxt = arrival_r + ARR_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '0;
      if (in_item.command == CMD_PUSH) begin
        out_item_nxt.status = is_full ? ST_FULL : ST_OK;
      end else if (is_empty) begin
        out_item_nxt.status = ST_EMPTY;
      end else begin
        out_item_nxt.status            = ST_OK;
        out_item_nxt.out_priority      = link[0].entry.prio;
        out_item_nxt.out_process_index = link[0].entry.pidx;
        out_item_nxt.out_payload       = link[0].entry.payload;
      end
      out_item_nxt.occupancy = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      arrival_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      arrival_r   <= arrival_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `MPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `MPQ_ASSERT_NOW(a_count_matches_cells, 1'b1, $countones(valid_vec) == count_r)
  `MPQ_ASSERT_NOW(a_cells_packed, 1'b1, ((valid_vec + 1'b1) & valid_vec) == '0)
  `MPQ_ASSERT_NEXT(a_pop_hit, ctrl.pop, out_valid_r && (out_item_r.status == ST_OK))

endmodule

`default_nettype wire
